>>> src/c2r_pkg.sv
// ----------------------------------------------------------------------------
// c2r_pkg
// Shared widths and types for the Cayley vector to rotation matrix unit.
// ----------------------------------------------------------------------------
package c2r_pkg;

  localparam int C_W   = 16;  // Cayley component width
  localparam int R_W   = 32;  // matrix entry width
  localparam int M_W   = 35;  // exact unscaled entry, signed
  localparam int S_W   = 32;  // 1 + |c|^2, unsigned
  localparam int REM_W = 34;  // divider partial remainder
  localparam int NLANE = 9;   // matrix entries

  typedef logic signed [C_W-1:0]   comp_t;
  typedef logic signed [R_W-1:0]   entry_t;
  typedef logic        [REM_W-1:0] rem_t;
  typedef logic        [S_W-1:0]   den_t;

endpackage

>>> src/c2r_if.sv
// ----------------------------------------------------------------------------
// c2r channel interfaces
// Valid/ready channels for Cayley vectors, matrices and the config write.
// ----------------------------------------------------------------------------
interface c2r_vec_if;
  logic          valid;
  logic          ready;
  c2r_pkg::comp_t c_x;
  c2r_pkg::comp_t c_y;
  c2r_pkg::comp_t c_z;
  modport source (output valid, c_x, c_y, c_z, input ready);
  modport sink   (input valid, c_x, c_y, c_z, output ready);
endinterface

interface c2r_mat_if;
  logic            valid;
  logic            ready;
  c2r_pkg::entry_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  output ready);
endinterface

interface c2r_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> src/c2r_div_step.sv
// ----------------------------------------------------------------------------
// c2r_div_step
// One restoring division step: shift (not in the first step), compare with divisor, subtract if not below.
// ----------------------------------------------------------------------------
module c2r_div_step #(
  parameter bit FIRST = 1'b0
) (
  input  c2r_pkg::rem_t rem_i,
  input  c2r_pkg::den_t den_i,
  output c2r_pkg::rem_t rem_o,
  output logic          bit_o
);

  c2r_pkg::rem_t shifted;
  c2r_pkg::rem_t den_w;

  assign den_w   = c2r_pkg::rem_t'(den_i);
  assign shifted = FIRST ? rem_i : {rem_i[c2r_pkg::REM_W-2:0], 1'b0};
  assign bit_o   = (shifted >= den_w);
  assign rem_o   = bit_o ? (shifted - den_w) : shifted;

endmodule

>>> src/cayley_to_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// cayley_to_rotation_matrix_unit
// Cayley vector (Q.IN_FRAC_BITS) to 3x3 rotation matrix (Q.OUT_FRAC_BITS).
//
// in_ch  : one Cayley vector per beat (c_x, c_y, c_z).
// out_ch : one matrix per beat (r00..r22), in input order.
// cfg_ch : one-bit normalize write, always ready; write only while idle.
//          1 divides every entry by 1 + |c|^2 (truncated toward zero),
//          0 gives the unscaled matrix.
// Pipeline: product stage, sum stage, sign/magnitude stage, OUT_FRAC_BITS + 1
// restoring divider stages, output register.
// Throughput: one vector per cycle while out_ch does not stall; the divider
// is fully pipelined.
// Reset empties the pipeline and sets normalize. When out_ch stalls the
// whole pipeline holds and in_ch.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module cayley_to_rotation_matrix_unit #(
  parameter int IN_FRAC_BITS  = 12,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  c2r_vec_if.sink   in_ch,
  c2r_mat_if.source out_ch,
  c2r_cfg_if.sink   cfg_ch
);

  localparam int MW    = c2r_pkg::M_W;
  localparam int NL    = c2r_pkg::NLANE;
  localparam int NQ    = OUT_FRAC_BITS + 1;
  localparam int TWO_I = 2 * IN_FRAC_BITS;
  localparam bit SHR   = (OUT_FRAC_BITS < TWO_I);
  localparam int K_R   = SHR ? (TWO_I - OUT_FRAC_BITS) : 0;
  localparam int K_L   = SHR ? 0 : (OUT_FRAC_BITS - TWO_I);
  localparam logic signed [MW-1:0] ONE_M = MW'(64'd1 << TWO_I);
  localparam logic signed [63:0]   BIAS  = (64'sd1 <<< K_R) - 64'sd1;

  typedef logic signed [2*c2r_pkg::C_W-1:0] prod_t;
  typedef logic signed [MW-1:0]             mval_t;
  typedef logic        [NQ-1:0]             quo_t;

  function automatic c2r_pkg::entry_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  logic en;
  logic normalize_r;

  assign en           = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normalize_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      normalize_r <= cfg_ch.data;
    end
  end

  // stage 1: products
  logic            v1_r, n1_r;
  c2r_pkg::comp_t  x1_r, y1_r, z1_r;
  prod_t           xx_r, yy_r, zz_r, xy_r, xz_r, yz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
    if (en) begin
      n1_r <= normalize_r;
      x1_r <= in_ch.c_x;
      y1_r <= in_ch.c_y;
      z1_r <= in_ch.c_z;
      xx_r <= in_ch.c_x * in_ch.c_x;
      yy_r <= in_ch.c_y * in_ch.c_y;
      zz_r <= in_ch.c_z * in_ch.c_z;
      xy_r <= in_ch.c_x * in_ch.c_y;
      xz_r <= in_ch.c_x * in_ch.c_z;
      yz_r <= in_ch.c_y * in_ch.c_z;
    end
  end

  // stage 2: unscaled matrix and denominator
  logic          v2_r, n2_r;
  mval_t         m2_r [NL];
  c2r_pkg::den_t s2_r;
  mval_t         m_nxt [NL];
  mval_t         wxx, wyy, wzz, wxy, wxz, wyz, xw, yw, zw, s_full;

  always_comb begin
    wxx = MW'(xx_r);
    wyy = MW'(yy_r);
    wzz = MW'(zz_r);
    wxy = MW'(xy_r);
    wxz = MW'(xz_r);
    wyz = MW'(yz_r);
    xw  = MW'(x1_r) <<< IN_FRAC_BITS;
    yw  = MW'(y1_r) <<< IN_FRAC_BITS;
    zw  = MW'(z1_r) <<< IN_FRAC_BITS;
    m_nxt[0] = ONE_M + wxx - wyy - wzz;
    m_nxt[1] = (wxy - zw) <<< 1;
    m_nxt[2] = (wxz + yw) <<< 1;
    m_nxt[3] = (wxy + zw) <<< 1;
    m_nxt[4] = ONE_M - wxx + wyy - wzz;
    m_nxt[5] = (wyz - xw) <<< 1;
    m_nxt[6] = (wxz - yw) <<< 1;
    m_nxt[7] = (wyz + xw) <<< 1;
    m_nxt[8] = ONE_M - wxx - wyy + wzz;
    s_full   = ONE_M + wxx + wyy + wzz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      n2_r <= n1_r;
      m2_r <= m_nxt;
      s2_r <= s_full[c2r_pkg::S_W-1:0];
    end
  end

  // stage 3: sign, magnitude, unscaled result
  logic            v3_r, n3_r;
  logic            neg3_r [NL];
  c2r_pkg::rem_t   mag3_r [NL];
  c2r_pkg::entry_t uns3_r [NL];
  c2r_pkg::den_t   s3_r;
  logic signed [63:0] wide [NL];
  logic signed [63:0] uw   [NL];
  mval_t              mabs [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      wide[l] = 64'(m2_r[l]);
      mabs[l] = m2_r[l][MW-1] ? -m2_r[l] : m2_r[l];
      if (SHR) begin
        uw[l] = m2_r[l][MW-1] ? ((wide[l] + BIAS) >>> K_R) : (wide[l] >>> K_R);
      end else begin
        uw[l] = wide[l] <<< K_L;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      n3_r <= n2_r;
      s3_r <= s2_r;
      for (int l = 0; l < NL; l++) begin
        neg3_r[l] <= m2_r[l][MW-1];
        mag3_r[l] <= mabs[l][c2r_pkg::REM_W-1:0];
        uns3_r[l] <= sat32(uw[l]);
      end
    end
  end

  // divider stages: one quotient bit per stage, MSB first
  logic            d_v_r   [NQ];
  logic            d_n_r   [NQ];
  c2r_pkg::den_t   d_den_r [NQ];
  c2r_pkg::rem_t   d_rem_r [NQ][NL];
  quo_t            d_q_r   [NQ][NL];
  logic            d_neg_r [NQ][NL];
  c2r_pkg::entry_t d_uns_r [NQ][NL];
  c2r_pkg::rem_t   st_rem  [NQ][NL];
  logic            st_bit  [NQ][NL];

  for (genvar k = 0; k < NQ; k++) begin : g_stage
    for (genvar l = 0; l < NL; l++) begin : g_lane
      if (k == 0) begin : g_first
        c2r_div_step #(.FIRST(1'b1)) u_step (
          .rem_i (mag3_r[l]),
          .den_i (s3_r),
          .rem_o (st_rem[k][l]),
          .bit_o (st_bit[k][l])
        );
      end else begin : g_next
        c2r_div_step #(.FIRST(1'b0)) u_step (
          .rem_i (d_rem_r[k-1][l]),
          .den_i (d_den_r[k-1]),
          .rem_o (st_rem[k][l]),
          .bit_o (st_bit[k][l])
        );
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NQ; k++) begin
        d_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      d_v_r[0] <= v3_r;
      for (int k = 1; k < NQ; k++) begin
        d_v_r[k] <= d_v_r[k-1];
      end
    end
    if (en) begin
      d_n_r[0]   <= n3_r;
      d_den_r[0] <= s3_r;
      for (int l = 0; l < NL; l++) begin
        d_rem_r[0][l] <= st_rem[0][l];
        d_q_r[0][l]   <= quo_t'(st_bit[0][l]);
        d_neg_r[0][l] <= neg3_r[l];
        d_uns_r[0][l] <= uns3_r[l];
      end
      for (int k = 1; k < NQ; k++) begin
        d_n_r[k]   <= d_n_r[k-1];
        d_den_r[k] <= d_den_r[k-1];
        for (int l = 0; l < NL; l++) begin
          d_rem_r[k][l] <= st_rem[k][l];
          d_q_r[k][l]   <= {d_q_r[k-1][l][NQ-2:0], st_bit[k][l]};
          d_neg_r[k][l] <= d_neg_r[k-1][l];
          d_uns_r[k][l] <= d_uns_r[k-1][l];
        end
      end
    end
  end

  // output register
  logic            out_v_r;
  c2r_pkg::entry_t out_r [NL];
  logic signed [NQ:0] qs [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      qs[l] = d_neg_r[NQ-1][l] ? -$signed({1'b0, d_q_r[NQ-1][l]})
                                :  $signed({1'b0, d_q_r[NQ-1][l]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= d_v_r[NQ-1];
    end
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        out_r[l] <= d_n_r[NQ-1] ? c2r_pkg::R_W'(qs[l]) : d_uns_r[NQ-1][l];
      end
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.r00   = out_r[0];
  assign out_ch.r01   = out_r[1];
  assign out_ch.r02   = out_r[2];
  assign out_ch.r10   = out_r[3];
  assign out_ch.r11   = out_r[4];
  assign out_ch.r12   = out_r[5];
  assign out_ch.r20   = out_r[6];
  assign out_ch.r21   = out_r[7];
  assign out_ch.r22   = out_r[8];

  // checks
  logic rem_ok;
  logic q_ok;

  always_comb begin
    rem_ok = 1'b1;
    q_ok   = 1'b1;
    for (int k = 0; k < NQ; k++) begin
      for (int l = 0; l < NL; l++) begin
        if (d_v_r[k] && (d_rem_r[k][l] >= c2r_pkg::rem_t'(d_den_r[k]))) begin
          rem_ok = 1'b0;
        end
      end
    end
    for (int l = 0; l < NL; l++) begin
      if (d_v_r[NQ-1] && (d_q_r[NQ-1][l] > (quo_t'(1) << OUT_FRAC_BITS))) begin
        q_ok = 1'b0;
      end
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n) rem_ok)
    else $error("divider remainder not below divisor");

  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n) q_ok)
    else $error("quotient magnitude above one");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
      (!en && v3_r) |=> v3_r)
    else $error("item dropped during stall");

  a_out_leaves_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
      $fell(out_v_r) |-> $past(out_ch.ready))
    else $error("result dropped without beat");

endmodule
